// ===== hdl/priority_ready_queue_unit_macros.svh =====
// Assertion macros shared by the ready queue RTL.
// No dependencies; included inside module bodies.
`ifndef PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// Shared types and constants for the priority ready queue.
// No dependencies.
package prq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 8;
   localparam int PRIORITY_BITS = 8;
   localparam int ADDR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   typedef struct packed {
      logic [ID_BITS-1:0]       id;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_FULL      = 2'd1,
      ERR_NOT_FOUND = 2'd2
   } err_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_START,
      ST_INS_WALK,
      ST_INS_LAST,
      ST_REM_START,
      ST_REM_WALK,
      ST_HEAD_RD,
      ST_HEAD_DATA,
      ST_OUT
   } state_type;

endpackage

// ===== hdl/prq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module prq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/priority_ready_queue_unit.sv =====
// Sorted ready queue: top level with the walk sequencer and the entry RAM.
// Depends on prq_pkg, prq_ram and priority_ready_queue_unit_macros.svh.

// Entries live in one RAM, head at address 0, highest priority first. One request is
// handled at a time. An insert walks from the tail toward the head, moving each lower
// or equal entry down one slot until it meets a higher one. A remove walks from the
// head, finds the first matching id and moves every later entry up one slot. Both
// walks cover one entry per cycle, which is the pace of the single RAM read port; a
// final read of address 0 fetches the head. A new request is taken while the previous
// result still waits.
module priority_ready_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [prq_pkg::ID_BITS-1:0]         req_task_id,
   input  logic [prq_pkg::PRIORITY_BITS-1:0]   req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prq_pkg::ID_BITS-1:0]         rsp_head_id,
   output logic [prq_pkg::PRIORITY_BITS-1:0]   rsp_head_priority,
   output logic                                rsp_queue_empty,
   output logic [1:0]                          rsp_error
);

   import prq_pkg::*;

   `include "priority_ready_queue_unit_macros.svh"

   state_type                state_ff, state_in;
   count_type                count_ff, count_in;
   addr_type                 k_ff, k_in;
   logic                     found_ff, found_in;
   action_type               act_ff, act_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   err_type                  err_ff, err_in;
   logic [ID_BITS-1:0]       res_id_ff, res_id_in;
   logic [PRIORITY_BITS-1:0] res_prio_ff, res_prio_in;
   logic                     res_empty_ff, res_empty_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   err_type                  rsp_err_ff, rsp_err_in;

   logic      mem_we;
   addr_type  mem_waddr;
   entry_type mem_wdata;
   logic      mem_re;
   addr_type  mem_raddr;
   entry_type mem_rdata;
   logic [ENTRY_BITS-1:0] mem_rbits;

   logic      req_take;
   logic      out_free;
   logic      ins_stop;
   logic      k_is_zero;
   logic      k_last;
   logic      id_hit;
   addr_type  tail_addr;
   entry_type new_entry;

   prq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign mem_rdata = entry_type'(mem_rbits);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign new_entry = '{id: id_ff, prio: prio_ff};
   // Stop the insert walk at the first entry that stays ahead of the new one.
   assign ins_stop  = (mem_rdata.prio > prio_ff);
   assign k_is_zero = (k_ff == '0);
   assign k_last    = ((COUNT_BITS'(k_ff) + COUNT_BITS'(1)) == count_ff);
   assign id_hit    = (mem_rdata.id == id_ff);
   assign tail_addr = ADDR_BITS'(count_ff - COUNT_BITS'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (action_type'(req_action) == ACT_INSERT) ? ST_INS_START
                                                                   : ST_REM_START;
            end
         end
         ST_INS_START: begin
            if (count_ff == COUNT_FULL || count_ff == '0) begin
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_INS_WALK;
            end
         end
         ST_INS_WALK: begin
            if (ins_stop) begin
               state_in = ST_HEAD_RD;
            end else if (k_is_zero) begin
               state_in = ST_INS_LAST;
            end
         end
         ST_INS_LAST:  state_in = ST_HEAD_RD;
         ST_REM_START: begin
            state_in = (count_ff == '0) ? ST_HEAD_RD : ST_REM_WALK;
         end
         ST_REM_WALK: begin
            if (k_last) begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            state_in = (count_ff == '0) ? ST_OUT : ST_HEAD_DATA;
         end
         ST_HEAD_DATA: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in     = count_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      act_in       = act_ff;
      id_in        = id_ff;
      prio_in      = prio_ff;
      err_in       = err_ff;
      res_id_in    = res_id_ff;
      res_prio_in  = res_prio_ff;
      res_empty_in = res_empty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = new_entry;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               act_in  = action_type'(req_action);
               id_in   = req_task_id;
               prio_in = req_priority_req;
               err_in  = ERR_OK;
            end
         end
         ST_INS_START: begin
            if (count_ff == COUNT_FULL) begin
               err_in = ERR_FULL;
            end else if (count_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = new_entry;
               count_in  = count_ff + COUNT_BITS'(1);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = tail_addr;
               k_in      = tail_addr;
            end
         end
         ST_INS_WALK: begin
            mem_we    = 1'b1;
            mem_waddr = k_ff + ADDR_BITS'(1);
            if (ins_stop) begin
               mem_wdata = new_entry;
               count_in  = count_ff + COUNT_BITS'(1);
            end else begin
               mem_wdata = mem_rdata;
               if (!k_is_zero) begin
                  mem_re    = 1'b1;
                  mem_raddr = k_ff - ADDR_BITS'(1);
                  k_in      = k_ff - ADDR_BITS'(1);
               end
            end
         end
         ST_INS_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = new_entry;
            count_in  = count_ff + COUNT_BITS'(1);
         end
         ST_REM_START: begin
            if (count_ff == '0) begin
               err_in = ERR_NOT_FOUND;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               k_in      = '0;
               found_in  = 1'b0;
            end
         end
         ST_REM_WALK: begin
            // entries after the first match move up one slot
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = k_ff - ADDR_BITS'(1);
               mem_wdata = mem_rdata;
            end
            found_in = found_ff | id_hit;
            if (k_last) begin
               if (found_ff | id_hit) begin
                  count_in = count_ff - COUNT_BITS'(1);
               end else begin
                  err_in = ERR_NOT_FOUND;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = k_ff + ADDR_BITS'(1);
               k_in      = k_ff + ADDR_BITS'(1);
            end
         end
         ST_HEAD_RD: begin
            if (count_ff == '0) begin
               res_id_in    = '0;
               res_prio_in  = '0;
               res_empty_in = 1'b1;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = '0;
            end
         end
         ST_HEAD_DATA: begin
            res_id_in    = mem_rdata.id;
            res_prio_in  = mem_rdata.prio;
            res_empty_in = 1'b0;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_prio_in  = res_prio_ff;
               rsp_empty_in = res_empty_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      found_ff     <= found_in;
      act_ff       <= act_in;
      id_ff        <= id_in;
      prio_ff      <= prio_in;
      err_ff       <= err_in;
      res_id_ff    <= res_id_in;
      res_prio_ff  <= res_prio_in;
      res_empty_ff <= res_empty_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_id       = rsp_id_ff;
   assign rsp_head_priority = rsp_prio_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_error         = rsp_err_ff;

   `PRQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_FULL, "entry count above depth")
   `PRQ_ASSERT_NEXT(a_take_starts, clock, reset, req_take, (state_ff == ST_INS_START && act_ff == ACT_INSERT) || (state_ff == ST_REM_START && act_ff == ACT_REMOVE), "accepted request did not start its walk")
   `PRQ_ASSERT_NOW(a_ins_not_full, clock, reset, state_ff == ST_INS_WALK || state_ff == ST_INS_LAST, count_ff < COUNT_FULL, "insert walk on a full queue")

endmodule
